// File: rtl/bptc_pkg.sv
// Shared types, widths and constants for the pressure/temperature compensation block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bptc_pkg;

  // Field widths
  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int TOUT_W = 15;
  localparam int POUT_W = 17;
  localparam int IDX_W  = 3;

  // Internal datapath widths, sized for the worst case of every input pattern
  localparam int DT_W    = RAW_W + 1;            // dT, signed
  localparam int MT_W    = DT_W + CAL_W + 1;     // dT times a coefficient, signed
  localparam int DD_W    = 2 * DT_W;             // dT squared, signed container
  localparam int A_W     = MT_W - 23;            // TEMP - 2000, signed
  localparam int T2_W    = 17;                   // dT^2 / 2^31, unsigned
  localparam int OFF1_W  = 36;                   // first-order OFF, signed
  localparam int SENS1_W = 35;                   // first-order SENS, signed
  localparam int B_W     = A_W + 1;              // TEMP + 1500, signed
  localparam int SQ_W    = 2 * B_W;              // squares, nonnegative
  localparam int CORR_W  = SQ_W + 4;             // OFF2 / SENS2, unsigned
  localparam int TEMP_W  = A_W + 2;              // corrected TEMP, signed
  localparam int FIN_W   = CORR_W + 2;           // corrected OFF / SENS, signed
  localparam int SPLIT   = 21;                   // SENS split point for the product
  localparam int LOP_W   = RAW_W + SPLIT;        // D1 * SENS low part, unsigned
  localparam int HIP_W   = 2 * (FIN_W - SPLIT);  // D1 * SENS high part, signed
  localparam int X_W     = HIP_W + 2;            // D1*SENS/2^21 - OFF, signed
  localparam int P_W     = X_W - 15;             // uncompensated-range pressure, signed

  localparam int NSTAGE  = 9;

  // Formula constants
  localparam int TEMP_BASE  = 2000;
  localparam int VCOLD_DIST = 3500;              // 2000 - (-1500)
  localparam int TEMP_MIN   = -4000;
  localparam int TEMP_MAX   = 8500;
  localparam int PRES_MIN   = 1000;
  localparam int PRES_MAX   = 120000;

  // Calibration register indexes
  localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order results leaving the front unit
  typedef struct packed {
    logic        [RAW_W-1:0]   d1;
    logic signed [A_W-1:0]     a;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic        [T2_W-1:0]    t2;
  } first_t;

  // Corrected values leaving the second-order unit
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [FIN_W-1:0]  off;
    logic signed [FIN_W-1:0]  sens;
  } corr_t;

endpackage

`default_nettype wire

// File: rtl/baro_pressure_temp_compensation.sv
// Barometric pressure/temperature compensation, top level.
// Depends on bptc_pkg, bptc_cfg, bptc_front, bptc_corr and bptc_pres.
//
// Usage:
//   Write calibration words C1..C6 on the cfg_ channel (index 0..5, 16-bit data)
//   while no item is in flight; cfg_ready is always high and other indexes are
//   dropped. Each input item carries one raw temperature (D2) and one raw pressure
//   (D1) conversion; each result item carries the compensated temperature in
//   0.01 degC, the compensated pressure in 0.01 mbar and a saturation flag.
//   Throughput: one item per cycle while out_tready is high. The accepting edge
//   loads the first of nine register stages (dT, products, first order, squares,
//   correction terms, corrected values, split pressure product, scale/offset,
//   saturation); out_tvalid is the valid bit of the last of them.
//   Each stage holds a valid bit; a stage advances when it is empty or the stage
//   after it advances, so a stall at out_tready only backs up full stages and
//   in_tready stays high while any bubble is left in the pipe.
//   Reset (rst_n low, synchronous) clears all valid bits and the calibration
//   words to zero; results then follow the formulas with zero calibration.
`default_nettype none

module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input items
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [47:0]      in_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
  // result items
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,  // [14:0] temperature_centi, [31:15] pressure_centi
  output logic                  out_tuser,  // [0] clamped
  // calibration writes
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0] cfg_data
);

  logic [NSTAGE-1:0] valid_r, valid_nxt;
  logic [NSTAGE-1:0] stage_en;

  cal_t   cal;
  first_t fst;
  corr_t  cor;

  logic [TOUT_W-1:0] temp_out;
  logic [POUT_W-1:0] pres_out;
  logic              clamp_out;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    stage_en[NSTAGE-1] = !valid_r[NSTAGE-1] || out_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[0]) begin
      valid_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (stage_en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready = stage_en[0];
  assign cfg_ready = 1'b1;

  bptc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cal      (cal)
  );

  // Stages 0..2: dT, products, first-order terms
  bptc_front u_front (
    .clk      (clk),
    .stage_en (stage_en[2:0]),
    .cal      (cal),
    .raw_t    (in_tdata[23:0]),
    .raw_p    (in_tdata[47:24]),
    .res      (fst)
  );

  // Stages 3..5: second-order correction
  bptc_corr u_corr (
    .clk      (clk),
    .stage_en (stage_en[5:3]),
    .fst      (fst),
    .res      (cor)
  );

  // Stages 6..8: pressure and saturation; stage 8 is the output register
  bptc_pres u_pres (
    .clk       (clk),
    .stage_en  (stage_en[8:6]),
    .cor       (cor),
    .temp_out  (temp_out),
    .pres_out  (pres_out),
    .clamp_out (clamp_out)
  );

  assign out_tvalid = valid_r[NSTAGE-1];
  assign out_tdata  = {pres_out, temp_out};
  assign out_tuser  = clamp_out;

endmodule

`default_nettype wire

// File: rtl/bptc_cfg.sv
// Calibration word registers C1..C6 with their write port.
// Depends on bptc_pkg.
`default_nettype none

module bptc_cfg
  import bptc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [CAL_W-1:0] wr_data,
  output cal_t                  cal
);

  cal_t cal_r;
  cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_C1:  cal_nxt.c1 = wr_data;
        REG_C2:  cal_nxt.c2 = wr_data;
        REG_C3:  cal_nxt.c3 = wr_data;
        REG_C4:  cal_nxt.c4 = wr_data;
        REG_C5:  cal_nxt.c5 = wr_data;
        REG_C6:  cal_nxt.c6 = wr_data;
        default: cal_nxt = cal_r;  // drop writes past the last word
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

`default_nettype wire

// File: rtl/bptc_front.sv
// First-order stages: dT, the four dT products, then TEMP, OFF, SENS and T2.
// Depends on bptc_pkg.
`default_nettype none

module bptc_front
  import bptc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [2:0]       stage_en,
  input  wire cal_t             cal,
  input  wire logic [RAW_W-1:0] raw_t,
  input  wire logic [RAW_W-1:0] raw_p,
  output first_t                res
);

  // stage 0
  logic signed [DT_W-1:0]  dt_r, dt_nxt;
  logic        [RAW_W-1:0] d1_0_r;
  // stage 1
  logic signed [MT_W-1:0]  mt_r, mt_nxt;
  logic signed [MT_W-1:0]  mo_r, mo_nxt;
  logic signed [MT_W-1:0]  ms_r, ms_nxt;
  logic signed [DD_W-1:0]  dd_r, dd_nxt;
  logic        [RAW_W-1:0] d1_1_r;
  // stage 2
  first_t                  res_r, res_nxt;

  // dT fits 25 bits signed, so the unsigned difference wraps to the right code
  assign dt_nxt = DT_W'(raw_t) - DT_W'({cal.c5, 8'h00});

  assign mt_nxt = dt_r * $signed({1'b0, cal.c6});
  assign mo_nxt = dt_r * $signed({1'b0, cal.c4});
  assign ms_nxt = dt_r * $signed({1'b0, cal.c3});
  assign dd_nxt = dt_r * dt_r;

  always_comb begin
    res_nxt.d1    = d1_1_r;
    res_nxt.a     = mt_r[MT_W-1:23];
    res_nxt.off1  = $signed({4'h0, cal.c2, 16'h0000}) + $signed(mo_r[MT_W-1:7]);
    res_nxt.sens1 = $signed({4'h0, cal.c1, 15'h0000}) + $signed(ms_r[MT_W-1:8]);
    res_nxt.t2    = dd_r[T2_W+31-1:31];
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dt_r   <= dt_nxt;
      d1_0_r <= raw_p;
    end
    if (stage_en[1]) begin
      mt_r   <= mt_nxt;
      mo_r   <= mo_nxt;
      ms_r   <= ms_nxt;
      dd_r   <= dd_nxt;
      d1_1_r <= d1_0_r;
    end
    if (stage_en[2]) begin
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/bptc_corr.sv
// Second-order stages: cold and very cold squares, correction terms, corrected values.
// Depends on bptc_pkg.
`default_nettype none

module bptc_corr
  import bptc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [2:0] stage_en,
  input  wire first_t     fst,
  output corr_t           res
);

  // stage 3
  logic                      cold_r, vcold_r;
  logic        [SQ_W-1:0]    sq1_r, sq2_r;
  logic signed [TEMP_W-1:0]  temp_3_r, temp_nxt;
  logic signed [OFF1_W-1:0]  off1_3_r;
  logic signed [SENS1_W-1:0] sens1_3_r;
  logic        [RAW_W-1:0]   d1_3_r;
  // stage 4
  logic        [CORR_W-1:0]  off2_r, off2_nxt;
  logic        [CORR_W-1:0]  sens2_r, sens2_nxt;
  logic signed [TEMP_W-1:0]  temp_4_r;
  logic signed [OFF1_W-1:0]  off1_4_r;
  logic signed [SENS1_W-1:0] sens1_4_r;
  logic        [RAW_W-1:0]   d1_4_r;
  // stage 5
  corr_t                     res_r, res_nxt;

  logic signed [B_W-1:0]  b;
  logic signed [SQ_W-1:0] sq_a, sq_b;
  logic        [CORR_W-1:0] sq1x, sq2x, five, seven, eleven;

  // TEMP < -1500 is the same as (TEMP - 2000) + 3500 < 0
  assign b    = B_W'(fst.a) + B_W'(VCOLD_DIST);
  assign sq_a = fst.a * fst.a;
  assign sq_b = b * b;

  assign temp_nxt = TEMP_W'(fst.a) + TEMP_W'(TEMP_BASE)
                  - (fst.a[A_W-1] ? TEMP_W'(fst.t2) : TEMP_W'(0));

  assign sq1x   = CORR_W'(sq1_r);
  assign sq2x   = CORR_W'(sq2_r);
  assign five   = sq1x + (sq1x << 2);
  assign seven  = (sq2x << 3) - sq2x;
  assign eleven = (sq2x << 3) + (sq2x << 1) + sq2x;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (cold_r) begin
      off2_nxt  = (five >> 1) + (vcold_r ? seven : CORR_W'(0));
      sens2_nxt = (five >> 2) + (vcold_r ? (eleven >> 1) : CORR_W'(0));
    end
  end

  always_comb begin
    res_nxt.d1   = d1_4_r;
    res_nxt.temp = temp_4_r;
    res_nxt.off  = FIN_W'(off1_4_r) - FIN_W'(off2_r);
    res_nxt.sens = FIN_W'(sens1_4_r) - FIN_W'(sens2_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      cold_r    <= fst.a[A_W-1];
      vcold_r   <= b[B_W-1];
      sq1_r     <= sq_a;
      sq2_r     <= sq_b;
      temp_3_r  <= temp_nxt;
      off1_3_r  <= fst.off1;
      sens1_3_r <= fst.sens1;
      d1_3_r    <= fst.d1;
    end
    if (stage_en[1]) begin
      off2_r    <= off2_nxt;
      sens2_r   <= sens2_nxt;
      temp_4_r  <= temp_3_r;
      off1_4_r  <= off1_3_r;
      sens1_4_r <= sens1_3_r;
      d1_4_r    <= d1_3_r;
    end
    if (stage_en[2]) begin
      res_r     <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/bptc_pres.sv
// Pressure stages: split D1*SENS product, scale and offset, then saturation.
// Depends on bptc_pkg.
`default_nettype none

module bptc_pres
  import bptc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [2:0]        stage_en,
  input  wire corr_t             cor,
  output logic [TOUT_W-1:0]      temp_out,
  output logic [POUT_W-1:0]      pres_out,
  output logic                   clamp_out
);

  // stage 6
  logic        [LOP_W-1:0]  lo_p_r, lo_p_nxt;
  logic signed [HIP_W-1:0]  hi_p_r, hi_p_nxt;
  logic signed [FIN_W-1:0]  off_6_r;
  logic signed [TEMP_W-1:0] temp_6_r;
  // stage 7
  logic signed [X_W-1:0]    x_r, x_nxt;
  logic signed [TEMP_W-1:0] temp_7_r;
  // stage 8
  logic [TOUT_W-1:0]        temp_out_r, temp_out_nxt;
  logic [POUT_W-1:0]        pres_out_r, pres_out_nxt;
  logic                     clamp_r, clamp_nxt;

  logic signed [P_W-1:0]    p;

  assign lo_p_nxt = cor.d1 * cor.sens[SPLIT-1:0];
  assign hi_p_nxt = $signed({1'b0, cor.d1}) * $signed(cor.sens[FIN_W-1:SPLIT]);

  // floor((hi*2^21 + lo) / 2^21) = hi + floor(lo / 2^21)
  assign x_nxt = X_W'(hi_p_r) + X_W'(lo_p_r[LOP_W-1:SPLIT]) - X_W'(off_6_r);

  assign p = x_r[X_W-1:15];

  always_comb begin
    logic temp_low, temp_high, pres_low, pres_high;
    temp_low     = temp_7_r < TEMP_MIN;
    temp_high    = temp_7_r > TEMP_MAX;
    pres_low     = p < PRES_MIN;
    pres_high    = p > PRES_MAX;
    temp_out_nxt = temp_7_r[TOUT_W-1:0];
    pres_out_nxt = p[POUT_W-1:0];
    if (temp_low) begin
      temp_out_nxt = TOUT_W'(TEMP_MIN);
    end else if (temp_high) begin
      temp_out_nxt = TOUT_W'(TEMP_MAX);
    end
    if (pres_low) begin
      pres_out_nxt = POUT_W'(PRES_MIN);
    end else if (pres_high) begin
      pres_out_nxt = POUT_W'(PRES_MAX);
    end
    clamp_nxt = temp_low | temp_high | pres_low | pres_high;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      lo_p_r   <= lo_p_nxt;
      hi_p_r   <= hi_p_nxt;
      off_6_r  <= cor.off;
      temp_6_r <= cor.temp;
    end
    if (stage_en[1]) begin
      x_r      <= x_nxt;
      temp_7_r <= temp_6_r;
    end
    if (stage_en[2]) begin
      temp_out_r <= temp_out_nxt;
      pres_out_r <= pres_out_nxt;
      clamp_r    <= clamp_nxt;
    end
  end

  assign temp_out  = temp_out_r;
  assign pres_out  = pres_out_r;
  assign clamp_out = clamp_r;

endmodule

`default_nettype wire

// File: rtl/bptc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
// Depends on bptc_pkg and baro_pressure_temp_compensation.
`default_nettype none

module bptc_checker
  import bptc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [31:0]      out_tdata,
  input wire logic             out_tuser
);

  logic signed [TOUT_W-1:0] temp_v;
  logic        [POUT_W-1:0] pres_v;

  assign temp_v = out_tdata[14:0];
  assign pres_v = out_tdata[31:15];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset empties the pipe
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (temp_v >= TEMP_MIN) && (temp_v <= TEMP_MAX))
    else $error("temperature out of range");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pres_v >= PRES_MIN) && (pres_v <= PRES_MAX))
    else $error("pressure out of range");

  // A flagged result sits on one of the saturation bounds
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (temp_v == TEMP_MIN) || (temp_v == TEMP_MAX)
                             || (pres_v == PRES_MIN) || (pres_v == PRES_MAX))
    else $error("clamp flag without a bound value");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);

`default_nettype wire

// File: bench/bptc_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the pressure/temperature compensation bench: a bit-exact predictor
// of the block plus the queue of readings it still owes. Depends on bptc_pkg.
package bptc_tb_pkg;
  import bptc_pkg::*;

  localparam int CAL_COUNT      = 6;
  localparam int TEMP_VERY_COLD = -1500;
  localparam int MAX_REPORTS    = 10;

  // Indexes past C6; the block drops writes to them
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [TOUT_W-1:0] temp_centi;
    logic        [POUT_W-1:0] pres_centi;
    logic                     clamped;
  } reading_t;

  class compensation_checker;
    logic [CAL_W-1:0] cal_words [CAL_COUNT];
    reading_t         expected_readings [$];
    int               mismatches;
    int               checked;

    function new();
      foreach (cal_words[i]) cal_words[i] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_cal(logic [IDX_W-1:0] index, logic [CAL_W-1:0] value);
      if (index <= REG_C6) cal_words[index] = value;
    endfunction

    // First-order terms, then the cold and very cold corrections, then saturation.
    // All power-of-two divisions floor, which >>> on a signed longint does.
    function reading_t compensate(logic [RAW_W-1:0] raw_temp, logic [RAW_W-1:0] raw_pres);
      longint   dt, temp, off, sens, t2, off2, sens2, sq, pres;
      bit       clamp;
      reading_t r;
      dt   = longint'(raw_temp) - (longint'(cal_words[REG_C5]) <<< 8);
      temp = TEMP_BASE + ((dt * longint'(cal_words[REG_C6])) >>> 23);
      off  = (longint'(cal_words[REG_C2]) <<< 16)
           + ((longint'(cal_words[REG_C4]) * dt) >>> 7);
      sens = (longint'(cal_words[REG_C1]) <<< 15)
           + ((longint'(cal_words[REG_C3]) * dt) >>> 8);
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      clamp = 1'b0;
      if (temp < TEMP_BASE) begin
        t2    = (dt * dt) >>> 31;
        sq    = (temp - TEMP_BASE) * (temp - TEMP_BASE);
        off2  = (5 * sq) >>> 1;
        sens2 = (5 * sq) >>> 2;
        if (temp < TEMP_VERY_COLD) begin
          sq    = (temp - TEMP_VERY_COLD) * (temp - TEMP_VERY_COLD);
          off2  += 7 * sq;
          sens2 += (11 * sq) >>> 1;
        end
      end
      temp -= t2;
      off  -= off2;
      sens -= sens2;
      pres = (((longint'(raw_pres) * sens) >>> 21) - off) >>> 15;
      if (temp < TEMP_MIN) begin temp = TEMP_MIN; clamp = 1'b1; end
      if (temp > TEMP_MAX) begin temp = TEMP_MAX; clamp = 1'b1; end
      if (pres < PRES_MIN) begin pres = PRES_MIN; clamp = 1'b1; end
      if (pres > PRES_MAX) begin pres = PRES_MAX; clamp = 1'b1; end
      r.temp_centi = temp[TOUT_W-1:0];
      r.pres_centi = pres[POUT_W-1:0];
      r.clamped    = clamp;
      return r;
    endfunction

    function void note_conversion(logic [RAW_W-1:0] raw_temp, logic [RAW_W-1:0] raw_pres);
      expected_readings.push_back(compensate(raw_temp, raw_pres));
    endfunction

    function void check_reading(logic [31:0] data, logic flag);
      reading_t got, want;
      got.temp_centi = data[TOUT_W-1:0];
      got.pres_centi = data[TOUT_W +: POUT_W];
      got.clamped    = flag;
      checked++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reading %0d unexpected: temp %0d pres %0d clamped %0b",
                   checked, got.temp_centi, got.pres_centi, got.clamped);
        return;
      end
      want = expected_readings.pop_front();
      if (got.temp_centi !== want.temp_centi || got.pres_centi !== want.pres_centi
          || got.clamped !== want.clamped) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reading %0d: expected temp %0d pres %0d clamped %0b, got %0d %0d %0b",
                   checked, want.temp_centi, want.pres_centi, want.clamped,
                   got.temp_centi, got.pres_centi, got.clamped);
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench for baro_pressure_temp_compensation: drives calibration and
// conversions, stalls the result side, checks readings. Depends on bptc_pkg, bptc_tb_pkg.
module tb_top;
  import bptc_pkg::*;
  import bptc_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 20;   // nine pipeline stages plus margin
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int HOLD_OFF_LEN    = 60;
  localparam int FILL_BURST      = 30;

  localparam logic [RAW_W-1:0] RAW_MAX    = 24'hFFFFFF;
  localparam logic [CAL_W-1:0] CAL_MAX    = 16'hFFFF;
  localparam logic [RAW_W-1:0] TYPICAL_D1 = 24'd9085466;
  localparam logic [RAW_W-1:0] TYPICAL_D2 = 24'd8569150;

  // Example calibration from the published application data, C1 first
  localparam logic [CAL_W-1:0] TYPICAL_CAL [CAL_COUNT] =
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
  localparam logic [IDX_W-1:0] CAL_INDEX [CAL_COUNT] =
    '{REG_C1, REG_C2, REG_C3, REG_C4, REG_C5, REG_C6};
  localparam logic [IDX_W-1:0] SPARE_INDEX [2] = '{REG_SPARE_LO, REG_SPARE_HI};

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;    // [23:0] raw_temperature, [47:24] raw_pressure
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // [14:0] temperature_centi, [31:15] pressure_centi
  logic              out_tuser;   // [0] clamped
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [CAL_W-1:0]  cfg_data;

  compensation_checker readings_sb;
  int                  hold_off_cycles = 0;

  baro_pressure_temp_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample every handshake on the edge; values seen here are the pre-edge ones,
  // since the bench drives everything with nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      readings_sb.write_cal(cfg_index, cfg_data);
    if (rst_n && in_tvalid && in_tready)
      readings_sb.note_conversion(in_tdata[RAW_W-1:0], in_tdata[2*RAW_W-1:RAW_W]);
    if (rst_n && out_tvalid && out_tready)
      readings_sb.check_reading(out_tdata, out_tuser);
  end

  // Result side: stall in segments of random mode and length. A requested
  // hold-off drops ready for a long stretch so the pipe fills and in_tready falls.
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       beat;
    mode     = RX_STEADY;
    seg_left = 0;
    beat     = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_left       = hold_off_cycles;
        hold_off_cycles = 0;
        out_tready <= 1'b0;
        repeat (hold_left) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      beat++;
      case (mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
        default:   out_tready <= (beat % 3 != 0);
      endcase
    end
  end

  // Give up on a hung block
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one conversion and hold it until the block takes it. Leave tvalid
  // high so back-to-back items need no second assignment in one step.
  task automatic send_conversion(input logic [RAW_W-1:0] raw_temp,
                                 input logic [RAW_W-1:0] raw_pres);
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_pres, raw_temp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write all six calibration words, optionally followed by writes to the
  // spare indexes, which must leave the calibration untouched.
  task automatic program_cal(input logic [CAL_W-1:0] words [CAL_COUNT], input bit with_spare);
    for (int i = 0; i < CAL_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CAL_INDEX[i];
      cfg_data  <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    if (with_spare) begin
      foreach (SPARE_INDEX[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= SPARE_INDEX[i];
        cfg_data  <= CAL_W'($urandom);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let the monitor catch up on the last accepted item, then
  // wait for every owed reading and let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CAL_W-1:0] cal_set [CAL_COUNT];
    logic [RAW_W-1:0] d2_pick;
    logic [RAW_W-1:0] d1_pick;
    longint           centered;
    int               burst_len;
    int               gap_len;
    int               sent;
    bit               fill_first;

    readings_sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_C1;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Unprogrammed calibration: all words still zero after reset
    send_conversion(24'd0, 24'd0);
    send_conversion(RAW_MAX, RAW_MAX);
    send_conversion(TYPICAL_D2, TYPICAL_D1);
    send_conversion(RAW_MAX, 24'd0);
    send_conversion(24'd0, RAW_MAX);
    wait_drained();

    // Typical calibration, plus writes to the unused indexes
    program_cal(TYPICAL_CAL, 1'b1);
    send_conversion(TYPICAL_D2, TYPICAL_D1);       // room temperature, normal pressure
    send_conversion(24'd8566784, TYPICAL_D1);      // dT = 0, TEMP exactly 20.00 C
    send_conversion(24'd8566783, TYPICAL_D1);      // just below 20 C, cold branch
    send_conversion(24'd7529764, TYPICAL_D1);      // TEMP exactly -15.00 C
    send_conversion(24'd7529763, TYPICAL_D1);      // just below -15 C, very cold branch
    send_conversion(24'd6789046, TYPICAL_D1);      // near -40 C
    send_conversion(24'd6500000, TYPICAL_D1);      // below -40 C, clamp low
    send_conversion(24'd10492662, TYPICAL_D1);     // near 85 C
    send_conversion(24'd11000000, TYPICAL_D1);     // above 85 C, clamp high
    send_conversion(24'd0, TYPICAL_D1);            // raw temperature floor
    send_conversion(RAW_MAX, TYPICAL_D1);          // raw temperature ceiling
    send_conversion(TYPICAL_D2, 24'd0);            // pressure below range
    send_conversion(TYPICAL_D2, RAW_MAX);          // pressure above range
    send_conversion(TYPICAL_D2, 24'd6000000);
    send_conversion(TYPICAL_D2, 24'd12000000);
    send_conversion(24'd7000000, 24'd7000000);     // cold and low pressure together
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1: foreach (cal_set[i]) cal_set[i] = CAL_MAX;
        2: foreach (cal_set[i]) cal_set[i] = CAL_W'($urandom);
        3: begin
          // no temperature coefficient: TEMP stays at 20 C
          foreach (cal_set[i]) cal_set[i] = CAL_W'($urandom);
          cal_set[REG_C6] = '0;
        end
        4: begin
          // zero reference with the steepest slope: mostly hot readings
          foreach (cal_set[i]) cal_set[i] = CAL_W'($urandom);
          cal_set[REG_C5] = '0;
          cal_set[REG_C6] = CAL_MAX;
        end
        default:
          foreach (cal_set[i])
            cal_set[i] = TYPICAL_CAL[i] + CAL_W'($urandom_range(0, 8191)) - CAL_W'(4096);
      endcase
      program_cal(cal_set, ph[0]);

      // In two phases, block the result side while a long burst keeps coming
      fill_first = (ph == 0 || ph == 3);
      if (fill_first) hold_off_cycles = HOLD_OFF_LEN;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst_len  = fill_first ? FILL_BURST : $urandom_range(1, 32);
        fill_first = 1'b0;
        for (int k = 0; k < burst_len && sent < ITEMS_PER_PHASE; k++) begin
          // Mostly temperatures around the reference point, where both cold
          // corrections and the hot clamp are reachable; some fully random.
          if ($urandom_range(0, 3) == 0) begin
            d2_pick = RAW_W'($urandom);
          end else begin
            centered = (longint'(cal_set[REG_C5]) <<< 8)
                     + longint'($urandom_range(0, 4194304)) - 2097152;
            if (centered < 0) centered = 0;
            if (centered > longint'(RAW_MAX)) centered = longint'(RAW_MAX);
            d2_pick = centered[RAW_W-1:0];
          end
          if ($urandom_range(0, 3) == 0)
            d1_pick = RAW_W'($urandom);
          else
            d1_pick = TYPICAL_D1 + RAW_W'($urandom_range(0, 2097152)) - RAW_W'(1048576);
          send_conversion(d2_pick, d1_pick);
          sent++;
        end
        case ($urandom_range(0, 5))
          0, 1:    gap_len = 0;
          5:       gap_len = $urandom_range(10, 25);
          default: gap_len = $urandom_range(1, 6);
        endcase
        if (gap_len > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap_len) @(posedge clk);
        end
      end
      wait_drained();
    end

    if (readings_sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bptc_pkg.sv
rtl/bptc_cfg.sv
rtl/bptc_front.sv
rtl/bptc_corr.sv
rtl/bptc_pres.sv
rtl/baro_pressure_temp_compensation.sv
rtl/bptc_checker.sv
bench/bptc_tb_pkg.sv
bench/tb_top.sv
